@@ hw/rtl/gated_frequency_counter_unit_macros.svh @@
// Assertion macros for the gated frequency counter
`ifndef GATED_FREQUENCY_COUNTER_UNIT_MACROS_SVH
`define GATED_FREQUENCY_COUNTER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/gfc_pkg.sv @@
// Shared constants of the gated frequency counter
`timescale 1ns / 1ps
package gfc_pkg;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 72;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_REF_DIVIDER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_TICKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_MS     = 2'd2;

	localparam logic [16:0] DIV_RESET   = 17'd1;
	localparam logic [16:0] DIV_MAX     = 17'd65536;
	localparam logic [31:0] TICKS_RESET = 32'd1000;
	localparam logic [15:0] MS_RESET    = 16'd1000;

	// 100 percent * 1000 ms/s * 2^16 (Q16.16)
	localparam logic [32:0] ERR_NUM = 33'd6553600000;

	localparam int DEN_W = 48;
endpackage

@@ hw/rtl/gated_frequency_counter_unit.sv @@
// Gated frequency counter: gate timing, pulse counting and result arithmetic
//
// Each input beat is one clock step of events (start request, reference tick,
// pulse edge); beats that do not close the gate can follow back to back. The
// beat that closes the gate starts the result arithmetic on one shared
// shift-subtract divider: frequency = count*1000/gate_ms, then
// error = 6553600000/(frequency*gate_ms), or zero at zero frequency. The divider
// numerator is NUM_W = max(COUNT_WIDTH+10, 33) bits wide, and s_tready stays
// low from the closing beat until the result is loaded into the output register.
// The result waits in an output register, so counting beats for the next
// measurement are taken while it is still unread.
`timescale 1ns / 1ps
module gated_frequency_counter_unit
	import gfc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // start_req, ref_tick, pulse_edge, zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // frequency[31:0], error_pct[63:32],
	                                         // count_saturated[64], zero pad
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);
	localparam int NUM_W = (COUNT_WIDTH + 10 > 33) ? COUNT_WIDTH + 10 : 33;
	localparam logic [COUNT_WIDTH-1:0] PULSE_MAX = '1;

	localparam logic [2:0] PH_COUNT   = 3'd0;
	localparam logic [2:0] PH_DIV1_GO = 3'd1;
	localparam logic [2:0] PH_DIV1    = 3'd2;
	localparam logic [2:0] PH_MUL     = 3'd3;
	localparam logic [2:0] PH_DIV2_GO = 3'd4;
	localparam logic [2:0] PH_DIV2    = 3'd5;
	localparam logic [2:0] PH_FINAL   = 3'd6;

	logic [16:0]            ref_div_q;
	logic [31:0]            gate_ticks_q;
	logic [15:0]            gate_ms_q;

	logic [2:0]             phase_q;
	logic                   busy_q;
	logic [15:0]            pre_q;
	logic [31:0]            gate_q;
	logic [COUNT_WIDTH-1:0] pulse_q;
	logic                   ovf_q;

	logic [31:0]            freq_q;
	logic [31:0]            err_q;
	logic                   sat_q;
	logic [DEN_W-1:0]       prod_q;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic                   start_req, ref_tick, pulse_edge;
	logic                   step, start_eff, closed;
	logic                   out_load;
	logic [16:0]            div_eff;
	logic [31:0]            ticks_eff;
	logic [15:0]            ms_eff;
	logic [15:0]            pre_base, pre_nxt;
	logic [31:0]            gate_base, gate_nxt;
	logic [COUNT_WIDTH-1:0] pulse_base, pulse_nxt;
	logic                   ovf_base, ovf_nxt;

	logic                   div_start, div_done;
	logic [NUM_W-1:0]       div_num, div_quo, pulse_ext;
	logic [DEN_W-1:0]       div_den;
	logic                   quo_high;

	assign start_req  = s_tdata[0];
	assign ref_tick   = s_tdata[1];
	assign pulse_edge = s_tdata[2];

	assign s_tready  = (phase_q == PH_COUNT);
	assign step      = s_tvalid && s_tready && (busy_q || start_req);
	assign start_eff = !busy_q && start_req;
	assign out_load  = (phase_q == PH_FINAL) && (!m_tvalid_q || m_tready);

	assign div_eff   = (ref_div_q == '0) ? 17'd1 : ((ref_div_q > DIV_MAX) ? DIV_MAX : ref_div_q);
	assign ticks_eff = (gate_ticks_q == '0) ? 32'd1 : gate_ticks_q;
	assign ms_eff    = (gate_ms_q == '0) ? 16'd1 : gate_ms_q;

	always_comb begin
		pre_base   = start_eff ? '0 : pre_q;
		gate_base  = start_eff ? '0 : gate_q;
		pulse_base = start_eff ? '0 : pulse_q;
		ovf_base   = start_eff ? 1'b0 : ovf_q;
		pulse_nxt  = pulse_base;
		ovf_nxt    = ovf_base;
		pre_nxt    = pre_base;
		gate_nxt   = gate_base;
		closed     = 1'b0;
		if (pulse_edge) begin
			if (pulse_base == PULSE_MAX) begin
				ovf_nxt = 1'b1;
			end else begin
				pulse_nxt = pulse_base + 1'b1;
			end
		end
		if (ref_tick) begin
			if ({1'b0, pre_base} + 17'd1 >= div_eff) begin
				pre_nxt = '0;
				if ({1'b0, gate_base} + 33'd1 >= {1'b0, ticks_eff}) begin
					closed = 1'b1;
				end else begin
					gate_nxt = gate_base + 1'b1;
				end
			end else begin
				pre_nxt = pre_base + 1'b1;
			end
		end
	end

	// count*1000 as shifts and subtracts
	assign pulse_ext = NUM_W'(pulse_q);
	assign div_start = (phase_q == PH_DIV1_GO) || (phase_q == PH_DIV2_GO);
	assign div_num   = (phase_q == PH_DIV1_GO)
		? (pulse_ext << 10) - (pulse_ext << 4) - (pulse_ext << 3)
		: NUM_W'(ERR_NUM);
	assign div_den   = (phase_q == PH_DIV1_GO) ? DEN_W'(ms_eff) : prod_q;
	assign quo_high  = |div_quo[NUM_W-1:32];

	gfc_div #(
		.NUM_W(NUM_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_div_q    <= DIV_RESET;
			gate_ticks_q <= TICKS_RESET;
			gate_ms_q    <= MS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REF_DIVIDER: ref_div_q    <= cfg_data[16:0];
				REG_GATE_TICKS:  gate_ticks_q <= cfg_data;
				REG_GATE_MS:     gate_ms_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_COUNT;
			busy_q     <= 1'b0;
			pre_q      <= '0;
			gate_q     <= '0;
			pulse_q    <= '0;
			ovf_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (phase_q)
				PH_COUNT: begin
					if (step) begin
						pre_q   <= pre_nxt;
						gate_q  <= gate_nxt;
						pulse_q <= pulse_nxt;
						ovf_q   <= ovf_nxt;
						busy_q  <= !closed;
						if (closed) begin
							phase_q <= PH_DIV1_GO;
						end
					end
				end
				PH_DIV1_GO: phase_q <= PH_DIV1;
				PH_DIV1: begin
					if (div_done) begin
						phase_q <= PH_MUL;
					end
				end
				PH_MUL:     phase_q <= (freq_q == '0) ? PH_FINAL : PH_DIV2_GO;
				PH_DIV2_GO: phase_q <= PH_DIV2;
				PH_DIV2: begin
					if (div_done) begin
						phase_q <= PH_FINAL;
					end
				end
				PH_FINAL: begin
					if (out_load) begin
						phase_q <= PH_COUNT;
					end
				end
				default: phase_q <= PH_COUNT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_DIV1 && div_done) begin
			freq_q <= quo_high ? '1 : div_quo[31:0];
			sat_q  <= ovf_q || quo_high;
		end
		if (phase_q == PH_MUL) begin
			prod_q <= freq_q * ms_eff;
			err_q  <= '0;
		end
		if (phase_q == PH_DIV2 && div_done) begin
			err_q <= quo_high ? '1 : div_quo[31:0];
		end
		if (out_load) begin
			m_tdata_q <= {7'd0, sat_q, err_q, freq_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
endmodule

@@ hw/rtl/gfc_div.sv @@
// Restoring shift-subtract divider, one quotient bit per cycle
`timescale 1ns / 1ps
module gfc_div
	import gfc_pkg::*;
#(
	parameter int NUM_W = 42
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

@@ hw/rtl/gfc_checker.sv @@
// Port-level checks of the gated frequency counter, bound to the top level
`timescale 1ns / 1ps
`include "gated_frequency_counter_unit_macros.svh"
module gfc_checker
	import gfc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);
	`GFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
	`GFC_ASSERT_NOW(a_err_zero_freq, m_tvalid && m_tdata[31:0] == 32'd0, m_tdata[63:32] == 32'd0, "error nonzero at zero frequency")
	`GFC_ASSERT_NOW(a_freq_sat_flag, m_tvalid && m_tdata[31:0] == 32'hFFFFFFFF, m_tdata[64], "saturated frequency without flag")
endmodule

bind gated_frequency_counter_unit gfc_checker u_gfc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
